// File: rtl/assert_macros.svh
// assertion macros for the text console block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, a, c)
`define CHK_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/tcce_pkg.sv
// package: widths, codes and font table of the text console block
package tcce_pkg;
  localparam int DEF_MAX_COLUMNS = 256;
  localparam int DEF_MAX_ROWS = 128;
  localparam int COL_CFG_W = 9;
  localparam int ROW_CFG_W = 8;
  localparam int COL_W = 8;
  localparam int ROW_W = 7;
  localparam logic [COL_CFG_W-1:0] COLS_RESET = 9'd80;
  localparam logic [ROW_CFG_W-1:0] ROWS_RESET = 8'd25;

  typedef enum logic [1:0] {
    OP_GLYPH  = 2'd0,
    OP_SCROLL = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_CURSOR = 2'd3
  } op_t;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_QMARK = 8'd63;
  localparam logic [7:0] CH_LAST_PRINT = 8'd126;

  typedef struct packed {
    logic [1:0]       op;
    logic [COL_W-1:0] cell_column;
    logic [ROW_W-1:0] cell_row;
    logic [2:0]       glyph_line;
    logic [7:0]       pixels;
    logic [COL_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_row;
    logic             last;
  } result_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic                 idx;
    logic [COL_CFG_W-1:0] data;
  } cfg_t;

  function automatic logic [34:0] glyph_bits(input logic [6:0] idx);
    logic [34:0] g;
    case (idx)
      7'd0: g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0};
      7'd1: g = {5'd4,5'd4,5'd4,5'd4,5'd4,5'd0,5'd4};
      7'd2: g = {5'd10,5'd10,5'd10,5'd0,5'd0,5'd0,5'd0};
      7'd3: g = {5'd10,5'd31,5'd10,5'd10,5'd31,5'd10,5'd0};
      7'd4: g = {5'd4,5'd15,5'd20,5'd14,5'd5,5'd30,5'd4};
      7'd5: g = {5'd24,5'd25,5'd2,5'd4,5'd8,5'd19,5'd3};
      7'd6: g = {5'd12,5'd18,5'd20,5'd8,5'd21,5'd18,5'd13};
      7'd7: g = {5'd4,5'd4,5'd8,5'd0,5'd0,5'd0,5'd0};
      7'd8: g = {5'd2,5'd4,5'd8,5'd8,5'd8,5'd4,5'd2};
      7'd9: g = {5'd8,5'd4,5'd2,5'd2,5'd2,5'd4,5'd8};
      7'd10: g = {5'd0,5'd21,5'd14,5'd31,5'd14,5'd21,5'd0};
      7'd11: g = {5'd0,5'd4,5'd4,5'd31,5'd4,5'd4,5'd0};
      7'd12: g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd4,5'd8};
      7'd13: g = {5'd0,5'd0,5'd0,5'd31,5'd0,5'd0,5'd0};
      7'd14: g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd4};
      7'd15: g = {5'd1,5'd1,5'd2,5'd4,5'd8,5'd16,5'd16};
      7'd16: g = {5'd14,5'd17,5'd19,5'd21,5'd25,5'd17,5'd14};
      7'd17: g = {5'd4,5'd12,5'd4,5'd4,5'd4,5'd4,5'd14};
      7'd18: g = {5'd14,5'd17,5'd1,5'd2,5'd4,5'd8,5'd31};
      7'd19: g = {5'd30,5'd1,5'd1,5'd14,5'd1,5'd1,5'd30};
      7'd20: g = {5'd2,5'd6,5'd10,5'd18,5'd31,5'd2,5'd2};
      7'd21: g = {5'd31,5'd16,5'd16,5'd30,5'd1,5'd1,5'd30};
      7'd22: g = {5'd6,5'd8,5'd16,5'd30,5'd17,5'd17,5'd14};
      7'd23: g = {5'd31,5'd1,5'd2,5'd4,5'd8,5'd8,5'd8};
      7'd24: g = {5'd14,5'd17,5'd17,5'd14,5'd17,5'd17,5'd14};
      7'd25: g = {5'd14,5'd17,5'd17,5'd15,5'd1,5'd2,5'd12};
      7'd26: g = {5'd0,5'd0,5'd4,5'd0,5'd0,5'd4,5'd0};
      7'd27: g = {5'd0,5'd0,5'd4,5'd0,5'd0,5'd4,5'd8};
      7'd28: g = {5'd2,5'd4,5'd8,5'd16,5'd8,5'd4,5'd2};
      7'd29: g = {5'd0,5'd0,5'd31,5'd0,5'd31,5'd0,5'd0};
      7'd30: g = {5'd8,5'd4,5'd2,5'd1,5'd2,5'd4,5'd8};
      7'd31: g = {5'd14,5'd17,5'd1,5'd2,5'd4,5'd0,5'd4};
      7'd32: g = {5'd14,5'd17,5'd23,5'd21,5'd23,5'd16,5'd14};
      7'd33: g = {5'd14,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17};
      7'd34: g = {5'd30,5'd17,5'd17,5'd30,5'd17,5'd17,5'd30};
      7'd35: g = {5'd14,5'd17,5'd16,5'd16,5'd16,5'd17,5'd14};
      7'd36: g = {5'd30,5'd17,5'd17,5'd17,5'd17,5'd17,5'd30};
      7'd37: g = {5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd31};
      7'd38: g = {5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd16};
      7'd39: g = {5'd14,5'd17,5'd16,5'd23,5'd17,5'd17,5'd15};
      7'd40: g = {5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17};
      7'd41: g = {5'd14,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14};
      7'd42: g = {5'd7,5'd2,5'd2,5'd2,5'd2,5'd18,5'd12};
      7'd43: g = {5'd17,5'd18,5'd20,5'd24,5'd20,5'd18,5'd17};
      7'd44: g = {5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd31};
      7'd45: g = {5'd17,5'd27,5'd21,5'd21,5'd17,5'd17,5'd17};
      7'd46: g = {5'd17,5'd25,5'd25,5'd21,5'd19,5'd19,5'd17};
      7'd47: g = {5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14};
      7'd48: g = {5'd30,5'd17,5'd17,5'd30,5'd16,5'd16,5'd16};
      7'd49: g = {5'd14,5'd17,5'd17,5'd17,5'd21,5'd18,5'd13};
      7'd50: g = {5'd30,5'd17,5'd17,5'd30,5'd20,5'd18,5'd17};
      7'd51: g = {5'd15,5'd16,5'd16,5'd14,5'd1,5'd1,5'd30};
      7'd52: g = {5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4};
      7'd53: g = {5'd17,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14};
      7'd54: g = {5'd17,5'd17,5'd17,5'd17,5'd17,5'd10,5'd4};
      7'd55: g = {5'd17,5'd17,5'd17,5'd21,5'd21,5'd27,5'd17};
      7'd56: g = {5'd17,5'd17,5'd10,5'd4,5'd10,5'd17,5'd17};
      7'd57: g = {5'd17,5'd17,5'd10,5'd4,5'd4,5'd4,5'd4};
      7'd58: g = {5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd31};
      7'd59: g = {5'd14,5'd8,5'd8,5'd8,5'd8,5'd8,5'd14};
      7'd60: g = {5'd16,5'd16,5'd8,5'd4,5'd2,5'd1,5'd1};
      7'd61: g = {5'd14,5'd2,5'd2,5'd2,5'd2,5'd2,5'd14};
      7'd62: g = {5'd4,5'd10,5'd17,5'd0,5'd0,5'd0,5'd0};
      7'd63: g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd31};
      7'd64: g = {5'd8,5'd4,5'd2,5'd0,5'd0,5'd0,5'd0};
      7'd65: g = {5'd0,5'd0,5'd14,5'd1,5'd15,5'd17,5'd15};
      7'd66: g = {5'd16,5'd16,5'd30,5'd17,5'd17,5'd17,5'd30};
      7'd67: g = {5'd0,5'd0,5'd14,5'd17,5'd16,5'd17,5'd14};
      7'd68: g = {5'd1,5'd1,5'd15,5'd17,5'd17,5'd17,5'd15};
      7'd69: g = {5'd0,5'd0,5'd14,5'd17,5'd31,5'd16,5'd14};
      7'd70: g = {5'd6,5'd9,5'd8,5'd28,5'd8,5'd8,5'd8};
      7'd71: g = {5'd0,5'd15,5'd17,5'd17,5'd15,5'd1,5'd14};
      7'd72: g = {5'd16,5'd16,5'd30,5'd17,5'd17,5'd17,5'd17};
      7'd73: g = {5'd4,5'd0,5'd12,5'd4,5'd4,5'd4,5'd14};
      7'd74: g = {5'd2,5'd0,5'd6,5'd2,5'd2,5'd18,5'd12};
      7'd75: g = {5'd16,5'd16,5'd18,5'd20,5'd24,5'd20,5'd18};
      7'd76: g = {5'd12,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14};
      7'd77: g = {5'd0,5'd0,5'd26,5'd21,5'd21,5'd21,5'd21};
      7'd78: g = {5'd0,5'd0,5'd30,5'd17,5'd17,5'd17,5'd17};
      7'd79: g = {5'd0,5'd0,5'd14,5'd17,5'd17,5'd17,5'd14};
      7'd80: g = {5'd0,5'd30,5'd17,5'd17,5'd30,5'd16,5'd16};
      7'd81: g = {5'd0,5'd15,5'd17,5'd17,5'd15,5'd1,5'd1};
      7'd82: g = {5'd0,5'd0,5'd22,5'd25,5'd16,5'd16,5'd16};
      7'd83: g = {5'd0,5'd0,5'd15,5'd16,5'd14,5'd1,5'd30};
      7'd84: g = {5'd8,5'd8,5'd28,5'd8,5'd8,5'd9,5'd6};
      7'd85: g = {5'd0,5'd0,5'd17,5'd17,5'd17,5'd19,5'd13};
      7'd86: g = {5'd0,5'd0,5'd17,5'd17,5'd17,5'd10,5'd4};
      7'd87: g = {5'd0,5'd0,5'd17,5'd17,5'd21,5'd21,5'd10};
      7'd88: g = {5'd0,5'd0,5'd17,5'd10,5'd4,5'd10,5'd17};
      7'd89: g = {5'd0,5'd17,5'd17,5'd17,5'd15,5'd1,5'd14};
      7'd90: g = {5'd0,5'd0,5'd31,5'd2,5'd4,5'd8,5'd31};
      7'd91: g = {5'd2,5'd4,5'd4,5'd8,5'd4,5'd4,5'd2};
      7'd92: g = {5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4};
      7'd93: g = {5'd8,5'd4,5'd4,5'd2,5'd4,5'd4,5'd8};
      7'd94: g = {5'd0,5'd0,5'd8,5'd21,5'd2,5'd0,5'd0};
      default: g = '0;
    endcase
    return g;
  endfunction

  // line 0 at the top; line 7 is blank
  function automatic logic [7:0] glyph_pixels(input logic [6:0] idx, input logic [2:0] line);
    logic [34:0] g;
    logic [4:0] b;
    g = glyph_bits(idx);
    case (line)
      3'd0: b = g[34:30];
      3'd1: b = g[29:25];
      3'd2: b = g[24:20];
      3'd3: b = g[19:15];
      3'd4: b = g[14:10];
      3'd5: b = g[9:5];
      3'd6: b = g[4:0];
      default: b = '0;
    endcase
    return {1'b0, b, 2'b00};
  endfunction
endpackage

// File: rtl/tcce_if.sv
// valid/ready channel interface
interface tcce_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/text_console_cursor_engine_unit.sv
// text console cursor engine: sequencer, cursor state and glyph line generator
//  channel | dir | payload
//  in_     | in  | kind, char_code
//  out_    | out | op, cell_column, cell_row, glyph_line, pixels, cursor, last
//  cfg_    | in  | idx, data (0 columns, 1 rows)
// results leave through a registered output stage; a byte is taken only when the last one is done.
// printable byte: 8 glyph lines, scroll check, cursor; 9 or 10 results;
// tab up to 37 results; control bytes and clear 1 or 2 results.
// the column adder serves the glyph step and the scroll compare the scroll step.
// reset is synchronous; a stalled output holds the sequencer.
`include "assert_macros.svh"
module text_console_cursor_engine_unit #(
  parameter int MAX_COLUMNS = tcce_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS = tcce_pkg::DEF_MAX_ROWS
) (
  input logic clk,
  input logic rst_n,
  tcce_if.sink   in_ch,
  tcce_if.source out_ch,
  tcce_if.sink   cfg_ch
);
  import tcce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_GLYPH  = 5'b00010,
    S_SCROLL = 5'b00100,
    S_CURSOR = 5'b01000,
    S_CLEAR  = 5'b10000
  } state_t;

  localparam logic [COL_CFG_W-1:0] MAXC = COL_CFG_W'(MAX_COLUMNS > 256 ? 256 : MAX_COLUMNS);
  localparam logic [ROW_CFG_W-1:0] MAXR = ROW_CFG_W'(MAX_ROWS > 128 ? 128 : MAX_ROWS);

  state_t state_r, state_nxt;
  logic [COL_CFG_W-1:0] cols_r;
  logic [ROW_CFG_W-1:0] rows_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [ROW_W:0] rowx_r, rowx_nxt;
  logic [7:0] code_r, code_nxt;
  logic [2:0] line_r, line_nxt;
  logic [2:0] spaces_r, spaces_nxt;
  logic valid_r, valid_nxt;
  result_t res_r, res_nxt;
  logic [COL_CFG_W-1:0] eff_cols;
  logic [ROW_CFG_W-1:0] eff_rows;
  logic can_go;
  logic [COL_CFG_W-1:0] col_inc;
  logic [7:0] draw_code;
  logic [6:0] gidx;
  logic need_scroll;

  always_comb begin
    eff_cols = cols_r;
    if (cols_r == '0) eff_cols = COL_CFG_W'(1);
    if (cols_r > MAXC) eff_cols = MAXC;
    eff_rows = rows_r;
    if (rows_r == '0) eff_rows = ROW_CFG_W'(1);
    if (rows_r > MAXR) eff_rows = MAXR;
  end

  assign can_go = !valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && can_go;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = valid_r;
  assign out_ch.data = res_r;
  assign col_inc = {1'b0, col_r} + COL_CFG_W'(1);
  assign draw_code = (code_r > CH_LAST_PRINT) ? CH_QMARK : code_r;
  assign gidx = 7'(draw_code - CH_SPACE);
  assign need_scroll = rowx_r >= eff_rows;

  always_comb begin
    state_nxt = state_r;
    col_nxt = col_r;
    row_nxt = row_r;
    rowx_nxt = rowx_r;
    code_nxt = code_r;
    line_nxt = line_r;
    spaces_nxt = spaces_r;
    valid_nxt = valid_r && !out_ch.ready;
    res_nxt = res_r;
    if (can_go) begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            code_nxt = in_ch.data.char_code;
            line_nxt = '0;
            rowx_nxt = {1'b0, row_r};
            if (in_ch.data.kind) begin
              state_nxt = S_CLEAR;
            end else if (in_ch.data.char_code == CH_LF) begin
              col_nxt = '0;
              rowx_nxt = {1'b0, row_r} + (ROW_W+1)'(1);
              state_nxt = S_SCROLL;
            end else if (in_ch.data.char_code == CH_CR) begin
              col_nxt = '0;
              state_nxt = S_SCROLL;
            end else if (in_ch.data.char_code == CH_BS) begin
              if (col_r != '0) begin
                col_nxt = col_r - COL_W'(1);
              end else if (row_r != '0) begin
                rowx_nxt = {1'b0, row_r} - (ROW_W+1)'(1);
                col_nxt = COL_W'(eff_cols - COL_CFG_W'(1));
              end
              state_nxt = S_SCROLL;
            end else if (in_ch.data.char_code == CH_TAB) begin
              code_nxt = CH_SPACE;
              spaces_nxt = 3'd4 - {1'b0, col_r[1:0]};
              state_nxt = S_GLYPH;
            end else if (in_ch.data.char_code >= CH_SPACE) begin
              spaces_nxt = 3'd1;
              state_nxt = S_GLYPH;
            end else begin
              state_nxt = S_SCROLL;
            end
          end
        end
        S_GLYPH: begin
          valid_nxt = 1'b1;
          res_nxt = '0;
          res_nxt.op = OP_GLYPH;
          res_nxt.cell_column = col_r;
          res_nxt.cell_row = row_r;
          res_nxt.glyph_line = line_r;
          res_nxt.pixels = glyph_pixels(gidx, line_r);
          res_nxt.cursor_column = col_r;
          res_nxt.cursor_row = row_r;
          line_nxt = line_r + 3'd1;
          if (line_r == 3'd7) begin
            spaces_nxt = spaces_r - 3'd1;
            if (col_inc >= eff_cols) begin
              col_nxt = '0;
              rowx_nxt = {1'b0, row_r} + (ROW_W+1)'(1);
            end else begin
              col_nxt = col_inc[COL_W-1:0];
              rowx_nxt = {1'b0, row_r};
            end
            state_nxt = S_SCROLL;
          end
        end
        S_SCROLL: begin
          row_nxt = rowx_r[ROW_W-1:0];
          if (need_scroll) begin
            row_nxt = ROW_W'(eff_rows - ROW_CFG_W'(1));
            valid_nxt = 1'b1;
            res_nxt = '0;
            res_nxt.op = OP_SCROLL;
            res_nxt.cell_row = row_nxt;
            res_nxt.cursor_column = col_r;
            res_nxt.cursor_row = row_nxt;
          end
          rowx_nxt = {1'b0, row_nxt};
          state_nxt = (spaces_r != '0) ? S_GLYPH : S_CURSOR;
        end
        S_CURSOR: begin
          valid_nxt = 1'b1;
          res_nxt = '0;
          res_nxt.op = OP_CURSOR;
          res_nxt.cursor_column = col_r;
          res_nxt.cursor_row = row_r;
          res_nxt.last = 1'b1;
          state_nxt = S_IDLE;
        end
        S_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
          valid_nxt = 1'b1;
          res_nxt = '0;
          res_nxt.op = OP_CLEAR;
          state_nxt = S_CURSOR;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
      col_r <= '0;
      row_r <= '0;
      valid_r <= 1'b0;
      spaces_r <= '0;
    end else begin
      state_r <= state_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      valid_r <= valid_nxt;
      spaces_r <= spaces_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.data.idx == REG_COLUMNS) cols_r <= cfg_ch.data.data;
        else rows_r <= cfg_ch.data.data[ROW_CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rowx_r <= rowx_nxt;
    code_r <= code_nxt;
    line_r <= line_nxt;
    res_r <= res_nxt;
  end

  `CHK_IMPL(a_busy_no_accept, clk, rst_n, state_r != S_IDLE, !in_ch.ready)
  `CHK_NEXT(a_stall_hold, clk, rst_n, valid_r && !out_ch.ready, valid_r && $stable(res_r))
  `CHK_NEXT(a_cursor_idle, clk, rst_n, can_go && state_r == S_CURSOR, state_r == S_IDLE)
endmodule
